@@ sv/sfd_pkg.sv @@
package sfd_pkg;

    // Sample and register widths
    localparam int SAMPLE_W   = 24;
    localparam int DELAY_W    = 17;
    localparam int DECAY_W    = 16;
    localparam int WET_W      = 17;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    // Ring geometry; depth is a power of two so pointer math wraps naturally
    localparam int RING_DEPTH = 131072;
    localparam int ADDR_W     = $clog2(RING_DEPTH);
    localparam int WIDE_W     = (ADDR_W > DELAY_W) ? ADDR_W : DELAY_W;

    // Datapath widths: product 24s x 18s, scaled accumulator, adder
    localparam int PROD_W = SAMPLE_W + WET_W + 1;
    localparam int ACC_W  = 44;
    localparam int SUM_W  = ACC_W + 1;
    localparam int STEP_W = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DELAY = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WET   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 4'd3;

    // Register reset values
    localparam logic [DELAY_W-1:0] DELAY_RST = 17'd24000;
    localparam logic [DECAY_W-1:0] DECAY_RST = 16'd4915;
    localparam logic [WET_W-1:0]   WET_RST   = 17'd32768;
    localparam logic [WET_W-1:0]   WET_FULL  = 17'd65536;

    localparam logic MODE_MONO   = 1'b0;
    localparam logic MODE_STEREO = 1'b1;

    // Multiplier A operand select
    localparam logic [2:0] A_LV   = 3'd0;
    localparam logic [2:0] A_RV   = 3'd1;
    localparam logic [2:0] A_INL  = 3'd2;
    localparam logic [2:0] A_INR  = 3'd3;
    localparam logic [2:0] A_MID  = 3'd4;
    localparam logic [2:0] A_MIX  = 3'd5;
    localparam logic [2:0] A_DWET = 3'd6;
    localparam logic [2:0] A_DDRY = 3'd7;

    // Multiplier B operand select
    localparam logic [1:0] B_WET   = 2'd0;
    localparam logic [1:0] B_DRY   = 2'd1;
    localparam logic [1:0] B_DECAY = 2'd2;
    localparam logic [1:0] B_ONE   = 2'd3;

    // Rounding shift on the adder result
    localparam logic [1:0] RND_NONE = 2'd0;
    localparam logic [1:0] RND_14   = 2'd1;
    localparam logic [1:0] RND_16   = 2'd2;

    // Accumulator load
    localparam logic [1:0] ACC_KEEP = 2'd0;
    localparam logic [1:0] ACC_RAW  = 2'd1;
    localparam logic [1:0] ACC_Y    = 2'd2;
    localparam logic [1:0] ACC_Z    = 2'd3;

    // Saturated result destination
    localparam logic [2:0] DST_NONE = 3'd0;
    localparam logic [2:0] DST_MIX  = 3'd1;
    localparam logic [2:0] DST_DWET = 3'd2;
    localparam logic [2:0] DST_OL   = 3'd3;
    localparam logic [2:0] DST_DDRY = 3'd4;
    localparam logic [2:0] DST_LW   = 3'd5;
    localparam logic [2:0] DST_OR   = 3'd6;
    localparam logic [2:0] DST_RW   = 3'd7;

    // One microcode word: multiply fields act this step, the rest act
    // on the product registered in the previous step
    typedef struct packed {
        logic [2:0] a_sel;
        logic [1:0] b_sel;
        logic       use_acc;
        logic [1:0] rnd;
        logic [1:0] acc_ld;
        logic [2:0] dst;
        logic       last;
    } t_uop;

    function automatic t_uop uop_rom(input logic mono, input logic [STEP_W-1:0] step);
        t_uop u;
        u = '0;
        if (mono) begin
            unique case (step)
                4'd0: begin
                    u.a_sel = A_LV;  u.b_sel = B_DECAY;
                end
                4'd1: begin
                    u.a_sel = A_INL; u.b_sel = B_ONE;
                    u.rnd = RND_14;  u.dst = DST_OL; u.acc_ld = ACC_Z;
                end
                4'd2: begin
                    u.use_acc = 1'b1; u.rnd = RND_16; u.dst = DST_LW; u.last = 1'b1;
                end
                default: u.last = 1'b1;
            endcase
        end else begin
            unique case (step)
                4'd0: begin
                    u.a_sel = A_RV;   u.b_sel = B_WET;
                end
                4'd1: begin
                    u.a_sel = A_LV;   u.b_sel = B_DRY;
                    u.acc_ld = ACC_RAW;
                end
                4'd2: begin
                    u.a_sel = A_LV;   u.b_sel = B_DECAY;
                    u.use_acc = 1'b1; u.rnd = RND_16; u.dst = DST_MIX;
                end
                4'd3: begin
                    u.a_sel = A_MIX;  u.b_sel = B_DECAY;
                    u.rnd = RND_14;   u.dst = DST_DWET;
                end
                4'd4: begin
                    u.a_sel = A_RV;   u.b_sel = B_DECAY;
                    u.rnd = RND_14;   u.dst = DST_OL; u.acc_ld = ACC_Z;
                end
                4'd5: begin
                    u.a_sel = A_INL;  u.b_sel = B_DRY;
                    u.rnd = RND_14;   u.dst = DST_DDRY;
                end
                4'd6: begin
                    u.a_sel = A_MID;  u.b_sel = B_WET;
                    u.use_acc = 1'b1; u.rnd = RND_16; u.acc_ld = ACC_Y;
                end
                4'd7: begin
                    u.a_sel = A_DDRY; u.b_sel = B_DRY;
                    u.use_acc = 1'b1; u.rnd = RND_16; u.dst = DST_LW;
                end
                4'd8: begin
                    u.a_sel = A_DWET; u.b_sel = B_WET;
                    u.rnd = RND_16;   u.acc_ld = ACC_Y;
                end
                4'd9: begin
                    u.a_sel = A_INR;  u.b_sel = B_DRY;
                    u.use_acc = 1'b1; u.rnd = RND_16; u.dst = DST_OR; u.acc_ld = ACC_Z;
                end
                4'd10: begin
                    u.use_acc = 1'b1; u.rnd = RND_16; u.dst = DST_RW; u.last = 1'b1;
                end
                default: u.last = 1'b1;
            endcase
        end
        return u;
    endfunction

    // Clamp to the signed sample range
    function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-SAMPLE_W:0] top;
        top = v[SUM_W-1:SAMPLE_W-1];
        if (top == '0 || top == '1) begin
            return v[SAMPLE_W-1:0];
        end else if (v[SUM_W-1]) begin
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            return {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    endfunction

endpackage

@@ sv/sfd_ram.sv @@
module sfd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 131072
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/stereo_feedback_delay_core.sv @@
// Frame flow: ring read, microcode steps on the multiplier, then write-back, which registers
//   the result for output. A new input frame is taken only once the last is written back; the
//   pace is set by the one shared 24x18 multiplier: ten products per stereo frame, two per mono
//   frame, plus ring read and write-back. Stalls while the sink holds the output register.
// Reset: synchronous, active low. Registers return to their defaults, write pointer to zero.
//   Rings are not swept; a fill flag makes entries not yet written read as zero.
module stereo_feedback_delay_core import sfd_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input frames
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [SAMPLE_W-1:0] i_in_left,
    input  logic signed [SAMPLE_W-1:0] i_in_right,
    // output frames
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_out_left,
    output logic signed [SAMPLE_W-1:0] o_out_right,
    // register writes
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data
);

    // Sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;  // ring read in flight
    localparam logic [1:0] ST_RUN   = 2'd2;  // microcode steps on the multiplier
    localparam logic [1:0] ST_WRITE = 2'd3;  // write-back and result hand-off

    logic [1:0]        r_state;
    logic [STEP_W-1:0] r_step;

    // Configuration registers
    logic [DELAY_W-1:0] r_delay;
    logic [DECAY_W-1:0] r_decay;
    logic [WET_W-1:0]   r_wet;
    logic               r_mode;

    // Ring pointer and fill flag (set once the pointer has wrapped)
    logic [ADDR_W-1:0] r_wi;
    logic              r_full;

    // Per-frame operands
    logic signed [SAMPLE_W-1:0] r_inl, r_inr;
    logic                       r_mono;
    logic                       r_rvalid;

    // Datapath
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [SAMPLE_W-1:0] r_mix, r_dwet, r_ddry, r_ol, r_lw, r_or, r_rw;

    // Output register
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_left, r_out_right;

    t_uop uop;
    logic in_acc, wr_go;

    // -------------------------------------------------------------------------
    // Ring read address: write pointer minus delay, wrapping over the ring.
    // The pointer moves only at write-back; a delay write mid-frame moves the address.
    // -------------------------------------------------------------------------
    logic [WIDE_W-1:0] rd_diff;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_valid;

    assign rd_diff  = WIDE_W'(r_wi) - WIDE_W'(r_delay);
    assign rd_addr  = rd_diff[ADDR_W-1:0];
    assign rd_valid = r_full || (rd_addr < r_wi);

    logic [SAMPLE_W-1:0] left_q, right_q;
    logic                left_we, right_we;
    logic [SAMPLE_W-1:0] right_wdata;

    sfd_ram #(.WIDTH(SAMPLE_W), .DEPTH(RING_DEPTH)) u_left_ring (
        .i_clk   (i_clk),
        .i_we    (left_we),
        .i_waddr (r_wi),
        .i_wdata (r_lw),
        .i_raddr (rd_addr),
        .o_rdata (left_q)
    );

    sfd_ram #(.WIDTH(SAMPLE_W), .DEPTH(RING_DEPTH)) u_right_ring (
        .i_clk   (i_clk),
        .i_we    (right_we),
        .i_waddr (r_wi),
        .i_wdata (right_wdata),
        .i_raddr (rd_addr),
        .o_rdata (right_q)
    );

    // Unwritten entries read as zero
    logic signed [SAMPLE_W-1:0] lv, rv;
    assign lv = r_rvalid ? $signed(left_q)  : '0;
    assign rv = r_rvalid ? $signed(right_q) : '0;

    // -------------------------------------------------------------------------
    // Handshakes
    // -------------------------------------------------------------------------
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    // write-back waits until the output register is free
    assign wr_go       = (r_state == ST_WRITE) && (!r_out_valid || i_out_ready);

    // Mono keeps the right ring as is; before the first wrap its entries are
    // still zero, so writing zero there matches and keeps the fill flag honest.
    assign left_we     = wr_go;
    assign right_we    = wr_go && (!r_mono || !r_full);
    assign right_wdata = r_mono ? '0 : r_rw;

    assign uop = uop_rom(r_mono, r_step);

    // -------------------------------------------------------------------------
    // Shared multiplier: signed sample times unsigned Q1.16/Q2.14 weight
    // -------------------------------------------------------------------------
    logic [WET_W-1:0]           wet_c, dry;
    logic signed [SAMPLE_W:0]   in_sum;
    logic signed [SAMPLE_W-1:0] mid;
    logic signed [SAMPLE_W-1:0] a_op;
    logic [WET_W-1:0]           b_op;
    logic signed [PROD_W-1:0]   prod;

    assign wet_c  = (r_wet > WET_FULL) ? WET_FULL : r_wet;
    assign dry    = WET_FULL - wet_c;
    assign in_sum = (SAMPLE_W+1)'(r_inl) + (SAMPLE_W+1)'(r_inr);
    assign mid    = in_sum[SAMPLE_W:1];   // floor of half the sum

    always_comb begin
        unique case (uop.a_sel)
            A_LV:   a_op = lv;
            A_RV:   a_op = rv;
            A_INL:  a_op = r_inl;
            A_INR:  a_op = r_inr;
            A_MID:  a_op = mid;
            A_MIX:  a_op = r_mix;
            A_DWET: a_op = r_dwet;
            A_DDRY: a_op = r_ddry;
        endcase
    end

    always_comb begin
        unique case (uop.b_sel)
            B_WET:   b_op = wet_c;
            B_DRY:   b_op = dry;
            B_DECAY: b_op = WET_W'(r_decay);
            B_ONE:   b_op = WET_FULL;
        endcase
    end

    assign prod = a_op * $signed({1'b0, b_op});

    // -------------------------------------------------------------------------
    // Accumulate, round and saturate the previous product.
    // The accumulator holds partial sums scaled by 2^16, so a later round by
    // 16 adds them back exactly: round(a*2^16 + p) = a + round(p).
    // -------------------------------------------------------------------------
    logic signed [SUM_W-1:0]    base, x, xr, y, rnd_half;
    logic signed [SAMPLE_W-1:0] z;
    logic signed [ACC_W-1:0]    n_acc;

    assign base = uop.use_acc ? SUM_W'(r_acc) : '0;
    assign x    = base + SUM_W'(r_prod);

    always_comb begin
        rnd_half = '0;
        y        = x;
        unique case (uop.rnd)
            RND_14: begin
                rnd_half[13] = 1'b1;
            end
            RND_16: begin
                rnd_half[15] = 1'b1;
            end
            default: begin
                rnd_half = '0;
            end
        endcase
        xr = x + rnd_half;
        unique case (uop.rnd)
            RND_14:  y = xr >>> 14;
            RND_16:  y = xr >>> 16;
            default: y = x;
        endcase
    end

    assign z = sat24(y);

    always_comb begin
        unique case (uop.acc_ld)
            ACC_RAW: n_acc = ACC_W'(x);
            ACC_Y:   n_acc = ACC_W'(y <<< 16);
            ACC_Z:   n_acc = ACC_W'(z) <<< 16;
            default: n_acc = r_acc;
        endcase
    end

    // -------------------------------------------------------------------------
    // Control
    // -------------------------------------------------------------------------
    logic [1:0]        n_state;
    logic [STEP_W-1:0] n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_RUN;
                n_step  = '0;
            end
            ST_RUN: begin
                if (uop.last) begin
                    n_state = ST_WRITE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_WRITE: begin
                if (wr_go) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_wi        <= '0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
            r_delay     <= DELAY_RST;
            r_decay     <= DECAY_RST;
            r_wet       <= WET_RST;
            r_mode      <= MODE_STEREO;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_DELAY: r_delay <= i_cfg_data[DELAY_W-1:0];
                    REG_DECAY: r_decay <= i_cfg_data[DECAY_W-1:0];
                    REG_WET:   r_wet   <= i_cfg_data[WET_W-1:0];
                    REG_MODE:  r_mode  <= i_cfg_data[0];
                    default: begin
                        // not a register: dropped
                    end
                endcase
            end

            if (wr_go) begin
                r_wi   <= r_wi + 1'b1;
                r_full <= r_full || (r_wi == '1);
            end

            if (wr_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // -------------------------------------------------------------------------
    // Datapath registers (no reset)
    // -------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_inl    <= i_in_left;
            r_inr    <= i_in_right;
            r_mono   <= (r_mode == MODE_MONO);
            r_rvalid <= rd_valid;
        end

        r_prod <= prod;

        if (r_state == ST_RUN) begin
            r_acc <= n_acc;
            unique case (uop.dst)
                DST_MIX:  r_mix  <= z;
                DST_DWET: r_dwet <= z;
                DST_OL:   r_ol   <= z;
                DST_DDRY: r_ddry <= z;
                DST_LW:   r_lw   <= z;
                DST_OR:   r_or   <= z;
                DST_RW:   r_rw   <= z;
                default: begin
                    // no capture
                end
            endcase
        end

        if (wr_go) begin
            r_out_left  <= r_ol;
            r_out_right <= r_mono ? '0 : r_or;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_left  = r_out_left;
    assign o_out_right = r_out_right;

endmodule

@@ sv/sfd_checker.sv @@
module sfd_checker import sfd_pkg::*; (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic signed [SAMPLE_W-1:0] o_out_left,
    input logic signed [SAMPLE_W-1:0] o_out_right,
    input logic                       i_cfg_valid,
    input logic                       o_cfg_ready,
    input logic [CFG_IDX_W-1:0]       i_cfg_index,
    input logic [CFG_DATA_W-1:0]      i_cfg_data
);

    logic       in_acc, out_acc, cfg_acc;
    logic [1:0] r_cnt;
    logic       r_mode;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;
    assign cfg_acc = i_cfg_valid && o_cfg_ready;

    // frames taken in but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_mode <= MODE_STEREO;
        end else begin
            r_cnt <= r_cnt + 2'(in_acc) - 2'(out_acc);
            if (cfg_acc && i_cfg_index == REG_MODE) begin
                r_mode <= i_cfg_data[0];
            end
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_out_left) && $stable(o_out_right))
        else $error("output request changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("input ready stayed high after a frame was taken");

    a_no_extra_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_cnt != 2'd0)
        else $error("output request without a pending frame");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> r_cnt <= 2'd1)
        else $error("more than two frames in flight");

    a_mono_right_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (r_mode == MODE_MONO) |-> o_out_right == '0)
        else $error("right output not zero in mono mode");

endmodule

bind stereo_feedback_delay_core sfd_checker u_sfd_checker (.*);
